// File: rtl/vpmwr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// vpmwr_pkg
// Shared types, constants and plane write and read functions for the planar memory.
// ============================================================================
package vpmwr_pkg;

    localparam int ADDR_W        = 16;
    localparam int DATA_W        = 8;
    localparam int PLANES        = 4;
    localparam int PLANE_W       = 2;
    localparam int WORD_W        = PLANES * DATA_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int DEF_ADDR_BITS = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic
    {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_SET_RESET        = 3'd0,
        REG_ENABLE_SET_RESET = 3'd1,
        REG_ROTATE_COUNT     = 3'd2,
        REG_LOGIC_FUNCTION   = 3'd3,
        REG_WRITE_MODE       = 3'd4,
        REG_BIT_MASK         = 3'd5,
        REG_MAP_MASK         = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        LOGIC_REPLACE = 2'd0,
        LOGIC_AND     = 2'd1,
        LOGIC_OR      = 2'd2,
        LOGIC_XOR     = 2'd3
    } logic_fn_t;

    typedef enum logic [1:0]
    {
        WMODE_NORMAL = 2'd0,
        WMODE_LATCH  = 2'd1,
        WMODE_EXPAND = 2'd2,
        WMODE_MASKED = 2'd3
    } wmode_t;

    typedef struct packed
    {
        logic [PLANES-1:0] set_reset;
        logic [PLANES-1:0] enable_set_reset;
        logic [2:0]        rotate_count;
        logic_fn_t         logic_function;
        wmode_t            write_mode;
        logic [DATA_W-1:0] bit_mask;
        logic [PLANES-1:0] map_mask;
    } cfg_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } item_t;

    // Combines a new byte with the latch byte through the ALU function.
    function automatic logic [DATA_W-1:0] apply_logic(
        input logic_fn_t         fn,
        input logic [DATA_W-1:0] v,
        input logic [DATA_W-1:0] latch
    );
        logic [DATA_W-1:0] r;
        unique case (fn)
            LOGIC_REPLACE: r = v;
            LOGIC_AND:     r = v & latch;
            LOGIC_OR:      r = v | latch;
            LOGIC_XOR:     r = v ^ latch;
        endcase
        return r;
    endfunction

    // Byte stored into one plane for a write, given the current latch byte.
    function automatic logic [DATA_W-1:0] plane_byte(
        input cfg_t               cfg,
        input logic [DATA_W-1:0]  data,
        input logic [DATA_W-1:0]  latch,
        input logic [PLANE_W-1:0] plane
    );
        logic [2*DATA_W-1:0] dd;
        logic [DATA_W-1:0]   rot;
        logic [DATA_W-1:0]   sr_fill;
        logic [DATA_W-1:0]   v;
        logic [DATA_W-1:0]   t;
        dd      = {data, data};
        rot     = dd[cfg.rotate_count +: DATA_W];
        sr_fill = {DATA_W{cfg.set_reset[plane]}};
        t       = data & cfg.bit_mask;
        unique case (cfg.write_mode)
            WMODE_NORMAL:
            begin
                v = cfg.enable_set_reset[plane] ? sr_fill : rot;
                v = apply_logic(cfg.logic_function, v, latch);
                v = (v & ~cfg.bit_mask) | (latch & cfg.bit_mask);
            end
            WMODE_LATCH:
            begin
                v = latch;
            end
            WMODE_EXPAND:
            begin
                v = cfg.enable_set_reset[plane] ? {DATA_W{data[plane]}} : data;
                v = apply_logic(cfg.logic_function, v, latch);
                v = (v & ~cfg.bit_mask) | (latch & cfg.bit_mask);
            end
            WMODE_MASKED:
            begin
                v = (sr_fill & ~t) | (latch & t);
            end
        endcase
        return v;
    endfunction

    // Byte of the lowest plane enabled in the map mask, zero if none.
    function automatic logic [DATA_W-1:0] read_select(
        input logic [WORD_W-1:0] word,
        input logic [PLANES-1:0] map_mask
    );
        logic [DATA_W-1:0] r;
        r = '0;
        for (int p = PLANES - 1; p >= 0; p--)
        begin
            if (map_mask[p])
            begin
                r = word[p*DATA_W +: DATA_W];
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/vpmwr_if.sv
`timescale 1ns / 1ps
// ============================================================================
// vpmwr_if
// Valid/ready channels for memory access items and read results.
// ============================================================================
interface vpmwr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [vpmwr_pkg::ADDR_W-1:0]  address;
    logic [vpmwr_pkg::DATA_W-1:0]  data;

    modport source (output valid, output cmd, output address, output data, input ready);
    modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

interface vpmwr_out_if;
    logic                          valid;
    logic                          ready;
    logic [vpmwr_pkg::DATA_W-1:0]  read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

// File: rtl/vpmwr_front.sv
`timescale 1ns / 1ps
// ============================================================================
// vpmwr_front
// Accepts access items, decodes the command and queues them for the back end.
// ============================================================================
module vpmwr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    vpmwr_in_if.sink             req,
    output vpmwr_pkg::item_t     q_item,
    output logic                 q_valid,
    input  logic                 q_pop
);

    localparam int PTR_W = (vpmwr_pkg::QUEUE_DEPTH > 1) ? $clog2(vpmwr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(vpmwr_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(vpmwr_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(vpmwr_pkg::QUEUE_DEPTH - 1);

    vpmwr_pkg::item_t  queue_reg [vpmwr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    vpmwr_pkg::item_t  new_item;
    logic              push;
    logic              pop;

    assign req.ready = (count_reg != FULL_CNT);
    assign push      = req.valid & req.ready;
    assign pop       = q_pop & q_valid;
    assign q_valid   = (count_reg != '0);
    assign q_item    = queue_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.cmd     = vpmwr_pkg::cmd_t'(req.cmd);
        new_item.address = req.address;
        new_item.data    = req.data;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: rtl/vpmwr_back.sv
`timescale 1ns / 1ps
// ============================================================================
// vpmwr_back
// Plane memory, read latches, write-mode datapath and result register.
// ============================================================================
module vpmwr_back
#(
    parameter int ADDR_BITS = vpmwr_pkg::DEF_ADDR_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  vpmwr_pkg::item_t     q_item,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  vpmwr_pkg::cfg_t      cfg,
    vpmwr_out_if.source          rsp
);

    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    logic [vpmwr_pkg::WORD_W-1:0] mem [MEM_DEPTH];
    logic [vpmwr_pkg::WORD_W-1:0] rdata_reg;
    logic [vpmwr_pkg::WORD_W-1:0] latch_reg, latch_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         out_valid_reg, out_valid_next;
    logic [vpmwr_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic [ADDR_BITS-1:0]         addr;
    logic [vpmwr_pkg::WORD_W-1:0] wdata;
    logic                         is_write;
    logic                         mem_we;
    logic                         mem_re;

    assign addr     = q_item.address[ADDR_BITS-1:0];
    assign is_write = (q_item.cmd == vpmwr_pkg::CMD_WRITE);

    // A read needs a free result register; nothing issues while a read is in flight.
    assign q_pop  = q_valid && !rd_pend_reg && (is_write || !out_valid_reg);
    assign mem_we = q_pop && is_write;
    assign mem_re = q_pop && !is_write;

    always_comb
    begin
        for (int p = 0; p < vpmwr_pkg::PLANES; p++)
        begin
            wdata[p*vpmwr_pkg::DATA_W +: vpmwr_pkg::DATA_W] =
                vpmwr_pkg::plane_byte(cfg, q_item.data,
                                      latch_reg[p*vpmwr_pkg::DATA_W +: vpmwr_pkg::DATA_W],
                                      vpmwr_pkg::PLANE_W'(p));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            for (int p = 0; p < vpmwr_pkg::PLANES; p++)
            begin
                if (cfg.map_mask[p])
                begin
                    mem[addr][p*vpmwr_pkg::DATA_W +: vpmwr_pkg::DATA_W] <=
                        wdata[p*vpmwr_pkg::DATA_W +: vpmwr_pkg::DATA_W];
                end
            end
        end
        if (mem_re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_comb
    begin
        latch_next     = latch_reg;
        rd_pend_next   = mem_re;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        if (rd_pend_reg)
        begin
            latch_next     = rdata_reg;
            out_valid_next = 1'b1;
            out_data_next  = vpmwr_pkg::read_select(rdata_reg, cfg.map_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            latch_reg     <= latch_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

endmodule

// File: rtl/vga_planar_memory_write_read.sv
`timescale 1ns / 1ps
// ============================================================================
// vga_planar_memory_write_read
// Four-plane video memory with graphics controller write modes and latches.
// ============================================================================
//
//  Channel   Direction  Handshake        Payload
//  req       in         valid / ready    cmd, address, data
//  rsp       out        valid / ready    read_data
//  cfg       in         cfg_we           cfg_index, cfg_data
//
// An accepted item waits in a two-entry queue before the back end takes it.
// A write is done at the memory port as the back end takes it, so writes
// stream at one item per cycle while no read is in flight. A read passes
// through the memory read register, then the latch load and result register;
// it issues only while the result register is empty. There is no clearing
// pass after reset. A stalled result holds the back end on reads only.
// ============================================================================
module vga_planar_memory_write_read
#(
    parameter int ADDR_BITS = vpmwr_pkg::DEF_ADDR_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    vpmwr_in_if.sink                        req,
    vpmwr_out_if.source                     rsp,
    input  logic                            cfg_we,
    input  logic [vpmwr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vpmwr_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Graphics controller registers. The user must change them only while the
    // block is idle; the block does not enforce this. The back end reads them directly.
    vpmwr_pkg::cfg_t  cfg_reg, cfg_next;
    vpmwr_pkg::item_t q_item;
    logic             q_valid;
    logic             q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (vpmwr_pkg::cfg_idx_t'(cfg_index))
                vpmwr_pkg::REG_SET_RESET:
                    cfg_next.set_reset = cfg_data[vpmwr_pkg::PLANES-1:0];
                vpmwr_pkg::REG_ENABLE_SET_RESET:
                    cfg_next.enable_set_reset = cfg_data[vpmwr_pkg::PLANES-1:0];
                vpmwr_pkg::REG_ROTATE_COUNT:
                    cfg_next.rotate_count = cfg_data[2:0];
                vpmwr_pkg::REG_LOGIC_FUNCTION:
                    cfg_next.logic_function = vpmwr_pkg::logic_fn_t'(cfg_data[1:0]);
                vpmwr_pkg::REG_WRITE_MODE:
                    cfg_next.write_mode = vpmwr_pkg::wmode_t'(cfg_data[1:0]);
                vpmwr_pkg::REG_BIT_MASK:
                    cfg_next.bit_mask = cfg_data;
                vpmwr_pkg::REG_MAP_MASK:
                    cfg_next.map_mask = cfg_data[vpmwr_pkg::PLANES-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accepts items, decodes the command and queues them.
    vpmwr_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // Back end: plane memory, latches, write datapath and result register.
    vpmwr_back
    #(
        .ADDR_BITS (ADDR_BITS)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .rsp     (rsp)
    );

endmodule

// File: bench/tb_vga_planar_memory_write_read.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_vga_planar_memory_write_read
// Self-checking bench for the four-plane video memory. Directed accesses
// cover each write mode, the logic functions, the extreme addresses, an
// empty map mask and the unused register index. Then randomized phases of
// read, modify and write sequences run under random register settings, with
// bursty request traffic and a stalling result side. A scoreboard mirrors
// the planes, the latches and the registers and checks every read byte in
// order.
// ============================================================================

class plane_scoreboard;

    vpmwr_pkg::cfg_t regs;
    logic [31:0]     latch_word;
    logic [31:0]     video_words [int];
    logic [7:0]      expected_bytes [$];
    int              errors;
    int              read_count;

    function new();
        regs       = '0;
        latch_word = '0;
        errors     = 0;
        read_count = 0;
    endfunction

    // Prints one line per mismatch and counts it.
    task report_mismatch(string what);
        errors++;
        $display("[%0t] ERROR %s", $time, what);
    endtask

    function void write_register(
        logic [vpmwr_pkg::CFG_IDX_W-1:0]  index,
        logic [vpmwr_pkg::CFG_DATA_W-1:0] value
    );
        case (index)
            vpmwr_pkg::REG_SET_RESET:
                regs.set_reset = value[3:0];
            vpmwr_pkg::REG_ENABLE_SET_RESET:
                regs.enable_set_reset = value[3:0];
            vpmwr_pkg::REG_ROTATE_COUNT:
                regs.rotate_count = value[2:0];
            vpmwr_pkg::REG_LOGIC_FUNCTION:
                regs.logic_function = vpmwr_pkg::logic_fn_t'(value[1:0]);
            vpmwr_pkg::REG_WRITE_MODE:
                regs.write_mode = vpmwr_pkg::wmode_t'(value[1:0]);
            vpmwr_pkg::REG_BIT_MASK:
                regs.bit_mask = value;
            vpmwr_pkg::REG_MAP_MASK:
                regs.map_mask = value[3:0];
            default: ;
        endcase
    endfunction

    // New contents of one plane byte for a write under the current registers.
    function logic [7:0] plane_result(int plane, logic [7:0] cpu, logic [7:0] old_latch);
        logic [15:0] doubled;
        logic [7:0]  sr_byte;
        logic [7:0]  source;
        logic [7:0]  combined;
        logic [7:0]  protect;
        logic [7:0]  result;
        doubled = {cpu, cpu} >> regs.rotate_count;
        sr_byte = regs.set_reset[plane] ? 8'hFF : 8'h00;
        case (regs.write_mode)
            vpmwr_pkg::WMODE_LATCH:
            begin
                result = old_latch;
            end
            vpmwr_pkg::WMODE_MASKED:
            begin
                protect = cpu & regs.bit_mask;
                result  = (sr_byte & ~protect) | (old_latch & protect);
            end
            default:
            begin
                if (!regs.enable_set_reset[plane])
                    source = (regs.write_mode == vpmwr_pkg::WMODE_NORMAL) ? doubled[7:0] : cpu;
                else if (regs.write_mode == vpmwr_pkg::WMODE_NORMAL)
                    source = sr_byte;
                else
                    source = {8{cpu[plane]}};
                case (regs.logic_function)
                    vpmwr_pkg::LOGIC_AND: combined = source & old_latch;
                    vpmwr_pkg::LOGIC_OR:  combined = source | old_latch;
                    vpmwr_pkg::LOGIC_XOR: combined = source ^ old_latch;
                    default:              combined = source;
                endcase
                result = (combined & ~regs.bit_mask) | (old_latch & regs.bit_mask);
            end
        endcase
        return result;
    endfunction

    function void note_access(vpmwr_pkg::cmd_t cmd, logic [15:0] address, logic [7:0] cpu);
        logic [31:0] word;
        logic [7:0]  picked;
        bit          found;
        word = video_words.exists(address) ? video_words[address] : 32'h0;
        if (cmd == vpmwr_pkg::CMD_READ)
        begin
            latch_word = word;
            picked     = 8'h00;
            found      = 1'b0;
            for (int p = 0; p < vpmwr_pkg::PLANES; p++)
            begin
                if (!found && regs.map_mask[p])
                begin
                    picked = word[8*p +: 8];
                    found  = 1'b1;
                end
            end
            expected_bytes.push_back(picked);
        end
        else
        begin
            for (int p = 0; p < vpmwr_pkg::PLANES; p++)
            begin
                if (regs.map_mask[p])
                begin
                    word[8*p +: 8] = plane_result(p, cpu, latch_word[8*p +: 8]);
                end
            end
            video_words[address] = word;
        end
    endfunction

    task check_read(logic [7:0] got);
        logic [7:0] want;
        read_count++;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch($sformatf("read result %0d arrived with no read outstanding",
                                      read_count));
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                report_mismatch($sformatf("read result %0d: read_data %02h, expected %02h",
                                          read_count, got, want));
            end
        end
    endtask

    task check_drained();
        if (expected_bytes.size() != 0)
        begin
            report_mismatch($sformatf("%0d read results never arrived",
                                      expected_bytes.size()));
        end
    endtask

    function int outstanding();
        return expected_bytes.size();
    endfunction

endclass

module tb_vga_planar_memory_write_read;

    // Index 7 has no register behind it; writes to it must be ignored.
    localparam logic [vpmwr_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    // A write produces no result, so these idle cycles let it leave the queue
    // and the memory port before a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1650;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [vpmwr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [vpmwr_pkg::CFG_DATA_W-1:0] cfg_data;

    vpmwr_in_if  req_ch();
    vpmwr_out_if rsp_ch();

    plane_scoreboard board = new();

    // Register settings currently loaded, as seen by the stimulus side.
    vpmwr_pkg::cfg_t active_cfg;
    // Planes written so far at each address. Only addresses with all four
    // planes written are ever read, since the memory holds garbage until then.
    logic [3:0]      planes_written [int];
    logic [15:0]     readable_addrs [$];
    // A few favored write targets so that reads and writes meet often.
    logic [15:0]     hot_addrs [$];
    // Sender pacing: items left in the current burst, and phases that never
    // idle the request side between bursts.
    int              burst_left;
    bit              steady_sender;

    vga_planar_memory_write_read uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Both handshakes are observed at the rising edge. A read accepted at an
    // edge cannot have its result at the same edge, so the two checks never
    // depend on each other's order.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            board.note_access(vpmwr_pkg::cmd_t'(req_ch.cmd), req_ch.address, req_ch.data);
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            board.check_read(rsp_ch.read_data);
        end
    end

    // The result side runs its own stall pattern: always ready, coin flips,
    // rare stalls, or long stalls separated by short ready windows. Each
    // pattern holds for a random span of cycles.
    initial
    begin : result_receiver
        int mode;
        int span;
        int hold;
        bit stalled;
        rsp_ch.ready = 1'b0;
        hold         = 0;
        stalled      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
                    default:
                    begin
                        if (hold == 0)
                        begin
                            stalled = !stalled;
                            hold    = stalled ? $urandom_range(1, 15) : $urandom_range(1, 4);
                        end
                        hold--;
                        rsp_ch.ready <= !stalled;
                    end
                endcase
            end
        end
    end

    // All driving tasks are entered and left at a falling edge.
    task automatic write_reg(
        logic [vpmwr_pkg::CFG_IDX_W-1:0]  index,
        logic [vpmwr_pkg::CFG_DATA_W-1:0] value
    );
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        board.write_register(index, value);
        @(negedge clk);
    endtask

    // Loads every register. With noise on, the bits above each register's
    // width carry junk, and the spare index gets a write as well.
    task automatic apply_settings(vpmwr_pkg::cfg_t s, bit noisy);
        logic [7:0] junk;
        junk = noisy ? 8'($urandom) : 8'h00;
        write_reg(vpmwr_pkg::REG_SET_RESET,        {junk[7:4], s.set_reset});
        write_reg(vpmwr_pkg::REG_ENABLE_SET_RESET, {junk[3:0], s.enable_set_reset});
        write_reg(vpmwr_pkg::REG_ROTATE_COUNT,     {junk[7:3], s.rotate_count});
        write_reg(vpmwr_pkg::REG_LOGIC_FUNCTION,   {junk[5:0], s.logic_function});
        write_reg(vpmwr_pkg::REG_WRITE_MODE,       {junk[7:2], s.write_mode});
        write_reg(vpmwr_pkg::REG_BIT_MASK,         s.bit_mask);
        write_reg(vpmwr_pkg::REG_MAP_MASK,         {junk[4:1], s.map_mask});
        if (noisy)
        begin
            write_reg(REG_SPARE, junk);
        end
        cfg_we     <= 1'b0;
        active_cfg  = s;
    endtask

    // Offers one item and returns once it has been accepted. Between bursts
    // the request side may go idle for a random number of cycles.
    task automatic send_access(vpmwr_pkg::cmd_t cmd, logic [15:0] address, logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= cmd;
        req_ch.address <= address;
        req_ch.data    <= data;
        if (cmd == vpmwr_pkg::CMD_WRITE)
        begin
            if (!planes_written.exists(address))
            begin
                planes_written[address] = 4'h0;
            end
            if (planes_written[address] != 4'hF &&
                (planes_written[address] | active_cfg.map_mask) == 4'hF)
            begin
                readable_addrs.push_back(address);
            end
            planes_written[address] |= active_cfg.map_mask;
        end
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering items until every read has delivered its result. At
    // least one falling edge passes, so valid is never lowered and raised in
    // the same step.
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (board.outstanding() != 0);
    endtask

    // Drains and then lets the last writes leave the pipeline, so the block
    // is idle for register writes.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_readable();
        return readable_addrs[$urandom_range(0, readable_addrs.size() - 1)];
    endfunction

    function automatic logic [15:0] pick_target();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
        if (roll < 8)
            return pick_readable();
        return 16'($urandom);
    endfunction

    // Register settings for one random phase: the all-zero and all-ones
    // extremes now and then, otherwise random fields with the map mask
    // leaning toward all planes so that new addresses become readable.
    function automatic vpmwr_pkg::cfg_t random_settings(int flavor);
        vpmwr_pkg::cfg_t s;
        int              roll;
        s = '0;
        if (flavor == 0)
            return s;
        if (flavor == 1)
        begin
            s.set_reset        = 4'hF;
            s.enable_set_reset = 4'hF;
            s.rotate_count     = 3'd7;
            s.logic_function   = vpmwr_pkg::LOGIC_XOR;
            s.write_mode       = vpmwr_pkg::WMODE_MASKED;
            s.bit_mask         = 8'hFF;
            s.map_mask         = 4'hF;
            return s;
        end
        s.set_reset        = 4'($urandom);
        s.enable_set_reset = 4'($urandom);
        s.rotate_count     = 3'($urandom);
        s.logic_function   = vpmwr_pkg::logic_fn_t'($urandom_range(0, 3));
        s.write_mode       = vpmwr_pkg::wmode_t'($urandom_range(0, 3));
        s.bit_mask         = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        roll = $urandom_range(0, 9);
        if (roll < 4)
            s.map_mask = 4'hF;
        else if (roll == 4)
            s.map_mask = 4'h0;
        else
            s.map_mask = 4'($urandom);
        return s;
    endfunction

    // One phase of random traffic. Most of it is the usual planar idiom:
    // read to fill the latches, write one to three bytes that draw on them,
    // and often read one back. The rest is loose writes anywhere in the
    // address space, lone reads, and a write followed at once by a read of
    // the same address once all of its planes are written.
    task automatic run_phase(int quota, output int sent);
        int          kind;
        int          writes;
        logic [15:0] a;
        logic [15:0] b;
        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0 && $urandom_range(0, 3) == 0)
            begin
                hold_until_drained();
            end
            if (kind < 6)
            begin
                a = pick_readable();
                b = a;
                send_access(vpmwr_pkg::CMD_READ, a, 8'($urandom));
                sent++;
                writes = $urandom_range(1, 3);
                repeat (writes)
                begin
                    b = $urandom_range(0, 1) ? a : pick_target();
                    send_access(vpmwr_pkg::CMD_WRITE, b, 8'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 1) && planes_written[b] == 4'hF)
                begin
                    send_access(vpmwr_pkg::CMD_READ, b, 8'($urandom));
                    sent++;
                end
            end
            else if (kind < 8)
            begin
                send_access(vpmwr_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
                sent++;
            end
            else if (kind == 8)
            begin
                send_access(vpmwr_pkg::CMD_READ, pick_readable(), 8'($urandom));
                sent++;
            end
            else
            begin
                a = pick_target();
                send_access(vpmwr_pkg::CMD_WRITE, a, 8'($urandom));
                sent++;
                if (planes_written[a] == 4'hF)
                begin
                    send_access(vpmwr_pkg::CMD_READ, a, 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        vpmwr_pkg::cfg_t s;
        int              done;
        int              quota;
        int              sent;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = vpmwr_pkg::CMD_READ;
        req_ch.address = '0;
        req_ch.data    = '0;
        active_cfg     = '0;
        burst_left     = 0;
        steady_sender  = 1'b1;
        hot_addrs      = {16'h0000, 16'hFFFF};
        repeat (22) hot_addrs.push_back(16'($urandom));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight out of reset the map mask is empty: the spare index is
        // written and must change nothing, and a write must leave memory
        // untouched.
        write_reg(REG_SPARE, 8'hFF);
        cfg_we <= 1'b0;
        send_access(vpmwr_pkg::CMD_WRITE, 16'h0000, 8'hA5);
        settle();

        // Plain replace writes at both ends of the address range and two
        // checkerboard addresses, then read them all back.
        s          = '0;
        s.map_mask = 4'hF;
        apply_settings(s, 1'b0);
        send_access(vpmwr_pkg::CMD_WRITE, 16'h0000, 8'h00);
        send_access(vpmwr_pkg::CMD_WRITE, 16'hFFFF, 8'hFF);
        send_access(vpmwr_pkg::CMD_WRITE, 16'h5A5A, 8'h81);
        send_access(vpmwr_pkg::CMD_WRITE, 16'hA5A5, 8'h7E);
        send_access(vpmwr_pkg::CMD_READ,  16'hFFFF, 8'h00);
        send_access(vpmwr_pkg::CMD_READ,  16'h0000, 8'hFF);
        send_access(vpmwr_pkg::CMD_READ,  16'h5A5A, 8'h00);
        send_access(vpmwr_pkg::CMD_READ,  16'hA5A5, 8'h00);
        settle();

        // Latch copy: load the all-ones word, copy it elsewhere, read it.
        s.write_mode = vpmwr_pkg::WMODE_LATCH;
        apply_settings(s, 1'b0);
        send_access(vpmwr_pkg::CMD_READ,  16'hFFFF, 8'h00);
        send_access(vpmwr_pkg::CMD_WRITE, 16'h1234, 8'h00);
        send_access(vpmwr_pkg::CMD_READ,  16'h1234, 8'h00);
        settle();

        // Data bit expansion on two planes, XOR with the latches, low nibble
        // kept from the latches. Junk rides above the register widths.
        s                  = '0;
        s.write_mode       = vpmwr_pkg::WMODE_EXPAND;
        s.enable_set_reset = 4'hA;
        s.logic_function   = vpmwr_pkg::LOGIC_XOR;
        s.bit_mask         = 8'h0F;
        s.map_mask         = 4'hF;
        apply_settings(s, 1'b1);
        send_access(vpmwr_pkg::CMD_READ,  16'h5A5A, 8'h00);
        send_access(vpmwr_pkg::CMD_WRITE, 16'h5A5A, 8'h55);
        send_access(vpmwr_pkg::CMD_READ,  16'h5A5A, 8'h00);
        settle();

        // Masked set/reset fill with the largest rotate, which this mode
        // must not apply.
        s                = '0;
        s.write_mode     = vpmwr_pkg::WMODE_MASKED;
        s.set_reset      = 4'h5;
        s.rotate_count   = 3'd7;
        s.bit_mask       = 8'hF0;
        s.logic_function = vpmwr_pkg::LOGIC_OR;
        s.map_mask       = 4'hF;
        apply_settings(s, 1'b0);
        send_access(vpmwr_pkg::CMD_WRITE, 16'hA5A5, 8'hFF);
        send_access(vpmwr_pkg::CMD_READ,  16'hA5A5, 8'h00);
        settle();

        // Rotated data and set/reset mixed per plane, ANDed with the latches,
        // with only the top plane enabled; the read returns that plane.
        s                  = '0;
        s.enable_set_reset = 4'h3;
        s.set_reset        = 4'hF;
        s.rotate_count     = 3'd3;
        s.logic_function   = vpmwr_pkg::LOGIC_AND;
        s.map_mask         = 4'h8;
        apply_settings(s, 1'b0);
        send_access(vpmwr_pkg::CMD_WRITE, 16'h0000, 8'hC3);
        send_access(vpmwr_pkg::CMD_READ,  16'h0000, 8'h00);
        settle();

        // Empty map mask again: the read gives zero but still loads the
        // latches, and the write is dropped.
        s = '0;
        apply_settings(s, 1'b0);
        send_access(vpmwr_pkg::CMD_READ,  16'hFFFF, 8'h00);
        send_access(vpmwr_pkg::CMD_WRITE, 16'hFFFF, 8'h12);
        settle();

        // OR with the latches through plane 2 alone.
        s.logic_function = vpmwr_pkg::LOGIC_OR;
        s.map_mask       = 4'h4;
        apply_settings(s, 1'b0);
        send_access(vpmwr_pkg::CMD_READ,  16'hFFFF, 8'h00);
        send_access(vpmwr_pkg::CMD_WRITE, 16'h1234, 8'h0F);
        send_access(vpmwr_pkg::CMD_READ,  16'h1234, 8'h00);
        settle();

        // Random phases, each with fresh register settings and its own
        // sender pacing.
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            s = random_settings($urandom_range(0, 11));
            apply_settings(s, 1'($urandom_range(0, 1)));
            steady_sender = ($urandom_range(0, 3) == 0);
            burst_left    = 0;
            quota         = $urandom_range(30, 80);
            run_phase(quota, sent);
            done += sent;
            settle();
        end

        board.check_drained();
        if (board.errors == 0)
        begin
            $display("vga_planar_memory_write_read: match");
        end
        else
        begin
            $display("vga_planar_memory_write_read: mismatch");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial
    begin : watchdog
        #5_000_000;
        $display("vga_planar_memory_write_read: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/vpmwr_pkg.sv
rtl/vpmwr_if.sv
rtl/vpmwr_front.sv
rtl/vpmwr_back.sv
rtl/vga_planar_memory_write_read.sv
bench/tb_vga_planar_memory_write_read.sv
